FILE: hdl/rcfe_pkg.sv
package rcfe_pkg;

  // Frame layout
  localparam int NUM_CHANNELS = 16;
  localparam int POS_W        = $clog2(NUM_CHANNELS);
  localparam int CH_W         = 11;
  localparam int VALUE_W      = 16;
  localparam int ACC_W        = 7;   // leftover bits after whole bytes leave
  localparam int HELD_W       = 3;
  localparam int GROUP_BYTES  = 4;
  localparam int GCOUNT_W     = 3;

  localparam logic [7:0] SYNC_BYTE      = 8'hC8;
  localparam logic [7:0] FRAME_LEN_BYTE = 8'd24;
  localparam logic [7:0] FRAME_TYPE_RC  = 8'h16;
  localparam logic [7:0] CRC_POLY       = 8'hD5;

  localparam logic [POS_W-1:0] LAST_POS = POS_W'(NUM_CHANNELS - 1);

  // Configuration register indexes
  localparam int CFG_INDEX_W = 2;
  localparam logic [CFG_INDEX_W-1:0] REG_CHANNEL_MIN = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_CHANNEL_MAX = 2'd1;

  localparam logic [CH_W-1:0] CHANNEL_MIN_RESET = 11'd172;
  localparam logic [CH_W-1:0] CHANNEL_MAX_RESET = 11'd1811;

  // One channel's worth of frame bytes, byte 0 leaves first
  typedef struct packed {
    logic [GROUP_BYTES-1:0][7:0] bytes;
    logic [GCOUNT_W-1:0]         count;
    logic                        last;
  } rcfe_group_t;

  // CRC-8, MSB first, one byte
  function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] data);
    logic [7:0] c;
    c = crc ^ data;
    for (int k = 0; k < 8; k++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

  // CRC after the type byte, start of every frame
  localparam logic [7:0] HEADER_CRC = crc8_update(8'h00, FRAME_TYPE_RC);

endpackage

FILE: hdl/rcfe_packer.sv
module rcfe_packer
  import rcfe_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [VALUE_W-1:0]  channel_value,
  input  logic [CH_W-1:0]     channel_min,
  input  logic [CH_W-1:0]     channel_max,
  output logic                grp_valid,
  output rcfe_group_t         grp,
  input  logic                grp_take
);

  // Input register
  logic               i_valid;
  logic [VALUE_W-1:0] i_value;
  logic               i_take;

  // Frame state
  logic [POS_W-1:0]  pos;
  logic [ACC_W-1:0]  acc;
  logic [HELD_W-1:0] held;
  logic [7:0]        crc;

  logic [POS_W-1:0]  pos_next;
  logic [ACC_W-1:0]  acc_next;
  logic [HELD_W-1:0] held_next;
  logic [7:0]        crc_next;
  rcfe_group_t       grp_next;

  // Combinational work
  logic               first;
  logic               last;
  logic [ACC_W-1:0]   acc_base;
  logic [HELD_W-1:0]  held_base;
  logic [7:0]         crc_base;
  logic [VALUE_W-1:0] raised;
  logic [VALUE_W-1:0] limited;
  logic [CH_W-1:0]    ch;
  logic [17:0]        packed_bits;
  logic [4:0]         total;
  logic               two;
  logic [7:0]         b0;
  logic [7:0]         b1;
  logic [7:0]         crc1;
  logic [7:0]         crc2;

  assign i_take   = i_valid && (!grp_valid || grp_take);
  assign in_ready = !i_valid || i_take;

  // Clamp, pack and checksum one channel
  always_comb begin
    first     = (pos == '0);
    last      = (pos == LAST_POS);
    acc_base  = first ? '0 : acc;
    held_base = first ? '0 : held;
    crc_base  = first ? HEADER_CRC : crc;

    // raise first, then lower: crossed limits give channel_max
    raised  = (i_value < {5'b0, channel_min}) ? {5'b0, channel_min} : i_value;
    limited = (raised > {5'b0, channel_max}) ? {5'b0, channel_max} : raised;
    ch      = limited[CH_W-1:0];

    packed_bits = {11'b0, acc_base} | ({7'b0, ch} << held_base);
    total       = {2'b0, held_base} + 5'd11;
    two         = (total >= 5'd16);
    b0          = packed_bits[7:0];
    b1          = packed_bits[15:8];

    crc1 = crc8_update(crc_base, b0);
    crc2 = two ? crc8_update(crc1, b1) : crc1;

    acc_next  = two ? {5'b0, packed_bits[17:16]} : packed_bits[14:8];
    held_next = two ? 3'(total - 5'd16) : 3'(total - 5'd8);
    crc_next  = crc2;
    pos_next  = pos + 1'b1;

    if (first) begin
      grp_next.bytes[0] = SYNC_BYTE;
      grp_next.bytes[1] = FRAME_LEN_BYTE;
      grp_next.bytes[2] = FRAME_TYPE_RC;
      grp_next.bytes[3] = b0;
      grp_next.count    = 3'd4;
      grp_next.last     = 1'b0;
    end else begin
      grp_next.bytes[0] = b0;
      grp_next.bytes[1] = two ? b1 : crc2;
      grp_next.bytes[2] = crc2;
      grp_next.bytes[3] = crc2;
      grp_next.count    = 3'd1 + {2'b0, two} + {2'b0, last};
      grp_next.last     = last;
    end
  end

  // Input register transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      i_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      i_valid <= 1'b1;
    end else if (i_take) begin
      i_valid <= 1'b0;
    end
    if (in_valid && in_ready) begin
      i_value <= channel_value;
    end
  end

  // State and group register
  always_ff @(posedge clk) begin
    if (rst) begin
      grp_valid <= 1'b0;
      pos       <= '0;
      acc       <= '0;
      held      <= '0;
      crc       <= '0;
    end else if (i_take) begin
      grp_valid <= 1'b1;
      pos       <= pos_next;
      acc       <= acc_next;
      held      <= held_next;
      crc       <= crc_next;
    end else if (grp_take) begin
      grp_valid <= 1'b0;
    end
    if (i_take) begin
      grp <= grp_next;
    end
  end

  a_grp_count: assert property (@(posedge clk) disable iff (rst)
    grp_valid |-> (grp.count != 3'd0 && grp.count <= 3'd4))
    else $error("group byte count out of range");

  a_grp_hold: assert property (@(posedge clk) disable iff (rst)
    grp_valid && !grp_take |=> grp_valid && $stable(grp))
    else $error("pending group lost or changed");

  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    i_valid && !i_take |=> i_valid && $stable(i_value))
    else $error("input register dropped a channel");

endmodule

FILE: hdl/rc_channel_frame_encoder.sv
// Bytes pass the input register, the group register and the output shifter.
// Throughput: one byte per cycle while out_ready is high; a channel gives 1 to 4
// bytes (26 bytes per 16-channel frame).
// An input register and a pending byte group keep input open while bytes drain.
// Reset (rst, synchronous): empties the pipeline, restarts at channel 0 and loads
// channel_min = 172, channel_max = 1811.
module rc_channel_frame_encoder
  import rcfe_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [VALUE_W-1:0]     channel_value,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [7:0]             frame_byte,
  output logic                   last_byte,
  input  logic                   cfg_write,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CH_W-1:0]        cfg_data
);

  logic [CH_W-1:0] channel_min;
  logic [CH_W-1:0] channel_max;

  logic        grp_valid;
  rcfe_group_t grp;
  logic        grp_take;

  // Output byte shifter
  logic [GROUP_BYTES-1:0][7:0] obuf;
  logic [GCOUNT_W-1:0]         ocnt;
  logic                        olast;
  logic                        o_load;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      channel_min <= CHANNEL_MIN_RESET;
      channel_max <= CHANNEL_MAX_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_CHANNEL_MIN: channel_min <= cfg_data;
        REG_CHANNEL_MAX: channel_max <= cfg_data;
        default: ;
      endcase
    end
  end

  rcfe_packer u_packer (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .channel_value (channel_value),
    .channel_min   (channel_min),
    .channel_max   (channel_max),
    .grp_valid     (grp_valid),
    .grp           (grp),
    .grp_take      (grp_take)
  );

  // Load a new group when empty or when the last byte leaves
  assign o_load   = !out_valid || (out_ready && ocnt == 3'd1);
  assign grp_take = grp_valid && o_load;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      ocnt      <= '0;
    end else if (o_load) begin
      out_valid <= grp_valid;
      if (grp_valid) begin
        ocnt <= grp.count;
      end else begin
        ocnt <= '0;
      end
    end else if (out_ready) begin
      ocnt <= ocnt - 1'b1;
    end
    if (o_load) begin
      if (grp_valid) begin
        obuf  <= grp.bytes;
        olast <= grp.last;
      end
    end else if (out_ready) begin
      obuf <= obuf >> 8;
    end
  end

  assign frame_byte = obuf[0];
  assign last_byte  = olast && (ocnt == 3'd1);

  a_out_count: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (ocnt != 3'd0))
    else $error("output valid with no bytes left");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(frame_byte) && $stable(last_byte))
    else $error("stalled output byte changed");

  a_take_load: assert property (@(posedge clk) disable iff (rst)
    grp_take |=> out_valid && ocnt == $past(grp.count))
    else $error("group transfer did not load the output");

endmodule
